// ----- src/kcl_pkg.sv -----
`default_nettype none

package kcl_pkg;

    localparam int P_CODE_LENGTH = 6;

    localparam logic [7:0] KEY_STAR = 8'd42;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_MAX_TRIES     = 1'b0;
    localparam logic REG_LOCKOUT_TICKS = 1'b1;

    localparam logic [3:0]  MAX_TRIES_RST     = 4'd3;
    localparam logic [15:0] LOCKOUT_TICKS_RST = 16'd10000;

    localparam logic [3:0] ST_STORED  = 4'd0;
    localparam logic [3:0] ST_SAVED   = 4'd1;
    localparam logic [3:0] ST_DIGIT   = 4'd2;
    localparam logic [3:0] ST_OPEN    = 4'd3;
    localparam logic [3:0] ST_WRONG   = 4'd4;
    localparam logic [3:0] ST_LOCKOUT = 4'd5;
    localparam logic [3:0] ST_SETMODE = 4'd6;
    localparam logic [3:0] ST_CLOSED  = 4'd7;
    localparam logic [3:0] ST_IGNORED = 4'd8;
    localparam logic [3:0] ST_READY   = 4'd9;

    typedef struct packed {
        logic [3:0] status;
        logic [3:0] tries_left;
        logic       unlocked;
    } t_result;

endpackage

`default_nettype wire

// ----- src/kcl_out_buf.sv -----
`default_nettype none

module kcl_out_buf
    import kcl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/keypad_code_lock.sv -----
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_command, i_key_code
// result    out        o_valid / i_stall   o_status, o_tries_left, o_unlocked
// config    in         i_cfg_we            i_cfg_addr, i_cfg_data
//
// One item per cycle while o_stall is low: each key or tick is decoded against
// the state registers in the cycle of its transfer and any result is registered.
// Results are registered in the output buffer, which drives o_valid.
// A two-entry output buffer absorbs a stalled result; o_stall is high only
// while both entries are full.
// Synchronous active-low reset; set mode, code unset, registers at defaults.
`default_nettype none

module keypad_code_lock
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = P_CODE_LENGTH
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_key_code,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_status,
    output logic [3:0]       o_tries_left,
    output logic             o_unlocked,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_data
);

    localparam int POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_LENGTH - 1);

    localparam logic [1:0] PH_SET     = 2'd0;
    localparam logic [1:0] PH_ENTRY   = 2'd1;
    localparam logic [1:0] PH_PROMPT  = 2'd2;
    localparam logic [1:0] PH_LOCKOUT = 2'd3;

    logic [3:0]       r_max_tries;
    logic [15:0]      r_lockout_ticks;
    logic [1:0]       r_phase,    n_phase;
    logic             r_code_set, n_code_set;
    logic [POS_W-1:0] r_position, n_position;
    logic             r_mismatch, n_mismatch;
    logic [3:0]       r_failed,   n_failed;
    logic [15:0]      r_lock_cnt, n_lock_cnt;
    logic [7:0]       r_code [CODE_LENGTH];

    logic       accept;
    logic       produce;
    logic       code_we;
    logic       miss;
    logic [3:0] fails_inc;
    t_result    res;
    t_result    out_data;
    logic       buf_full;

    assign accept    = i_valid && !buf_full;
    assign o_stall   = buf_full;
    assign miss      = r_mismatch || (r_code[r_position] != i_key_code);
    assign fails_inc = r_failed + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_code_set = r_code_set;
        n_position = r_position;
        n_mismatch = r_mismatch;
        n_failed   = r_failed;
        n_lock_cnt = r_lock_cnt;
        code_we    = 1'b0;
        produce    = 1'b1;
        res        = '{status: ST_IGNORED, tries_left: 4'd0, unlocked: 1'b0};
        if (i_command == CMD_TICK) begin
            produce = 1'b0;
            if (r_phase == PH_LOCKOUT) begin
                if (r_lock_cnt > 16'd1) begin
                    n_lock_cnt = r_lock_cnt - 16'd1;
                end else begin
                    n_lock_cnt = 16'd0;
                    n_failed   = 4'd0;
                    n_phase    = PH_ENTRY;
                    produce    = 1'b1;
                    res.status = ST_READY;
                end
            end
        end else begin
            case (r_phase)
                PH_SET: begin
                    if (i_key_code != KEY_STAR) begin
                        code_we = 1'b1;
                        if (r_position == LAST_POS) begin
                            n_position   = '0;
                            n_phase      = r_code_set ? PH_ENTRY : PH_PROMPT;
                            n_code_set   = 1'b1;
                            res.status   = ST_SAVED;
                            res.unlocked = 1'b1;
                        end else begin
                            n_position = r_position + POS_W'(1);
                            res.status = ST_STORED;
                        end
                    end
                end
                PH_ENTRY: begin
                    if (r_position != LAST_POS) begin
                        n_position = r_position + POS_W'(1);
                        n_mismatch = miss;
                        res.status = ST_DIGIT;
                    end else begin
                        n_position = '0;
                        n_mismatch = 1'b0;
                        if (!miss) begin
                            n_failed     = 4'd0;
                            n_phase      = PH_PROMPT;
                            res.status   = ST_OPEN;
                            res.unlocked = 1'b1;
                        end else if (fails_inc >= r_max_tries) begin
                            n_failed   = 4'd0;
                            n_lock_cnt = r_lockout_ticks;
                            n_phase    = PH_LOCKOUT;
                            res.status = ST_LOCKOUT;
                        end else begin
                            n_failed       = fails_inc;
                            res.status     = ST_WRONG;
                            res.tries_left = r_max_tries - fails_inc;
                        end
                    end
                end
                PH_PROMPT: begin
                    n_position = '0;
                    if (i_key_code == KEY_STAR) begin
                        n_phase    = PH_SET;
                        res.status = ST_SETMODE;
                    end else begin
                        n_phase    = PH_ENTRY;
                        n_mismatch = 1'b0;
                        res.status = ST_CLOSED;
                    end
                end
                default: begin
                    res.status = ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tries     <= MAX_TRIES_RST;
            r_lockout_ticks <= LOCKOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MAX_TRIES:     r_max_tries     <= i_cfg_data[3:0];
                REG_LOCKOUT_TICKS: r_lockout_ticks <= i_cfg_data;
                default:           r_max_tries     <= r_max_tries;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SET;
            r_code_set <= 1'b0;
            r_position <= '0;
            r_mismatch <= 1'b0;
            r_failed   <= 4'd0;
            r_lock_cnt <= 16'd0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_code_set <= n_code_set;
            r_position <= n_position;
            r_mismatch <= n_mismatch;
            r_failed   <= n_failed;
            r_lock_cnt <= n_lock_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && code_we) begin
            r_code[r_position] <= i_key_code;
        end
    end

    kcl_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && produce),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_status     = out_data.status;
    assign o_tries_left = out_data.tries_left;
    assign o_unlocked   = out_data.unlocked;

    a_prompt_needs_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PROMPT || r_phase == PH_ENTRY) |-> r_code_set)
        else $error("prompt or entry reached without a stored code");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PROMPT || r_phase == PH_LOCKOUT) |-> (r_position == '0))
        else $error("position not cleared outside set and entry");

    a_tries_only_wrong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_WRONG) |-> (o_tries_left == 4'd0))
        else $error("tries_left set on a result other than wrong");

    a_unlocked_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_unlocked) |-> (o_status == ST_OPEN || o_status == ST_SAVED))
        else $error("unlocked on a result other than open or saved");

    a_lockout_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_TICK && r_phase != PH_LOCKOUT) |=> $stable(r_phase))
        else $error("tick changed phase outside lockout");

endmodule

`default_nettype wire
